// ===== rtl/marching_squares_cell_segments_top_defines.svh =====
// Assertion macros for the marching squares segment top level
`ifndef MARCHING_SQUARES_CELL_SEGMENTS_TOP_DEFINES_SVH
`define MARCHING_SQUARES_CELL_SEGMENTS_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MSQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msq check failed");

// next-cycle implication, disabled during reset
`define MSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msq check failed");

`endif

// ===== rtl/msq_pkg.sv =====
// Package: default widths and the segment table for the marching squares block
package msq_pkg;

  localparam int GRID_BITS_DEF   = 10;
  localparam int FRAC_BITS_DEF   = 12;
  localparam int SAMPLE_BITS_DEF = 16;

  // per case, per segment: {a, b, c, d} corner pairs of the two endpoints
  localparam logic [7:0] SEG_TBL [16][2] = '{
    '{8'h00, 8'h00},
    '{{2'd0, 2'd2, 2'd0, 2'd1}, 8'h00},
    '{{2'd0, 2'd1, 2'd1, 2'd3}, 8'h00},
    '{{2'd0, 2'd2, 2'd1, 2'd3}, 8'h00},
    '{{2'd0, 2'd2, 2'd2, 2'd3}, 8'h00},
    '{{2'd0, 2'd1, 2'd2, 2'd3}, 8'h00},
    '{{2'd0, 2'd1, 2'd0, 2'd2}, {2'd2, 2'd3, 2'd1, 2'd3}},
    '{{2'd2, 2'd3, 2'd1, 2'd3}, 8'h00},
    '{{2'd2, 2'd3, 2'd1, 2'd3}, 8'h00},
    '{{2'd0, 2'd1, 2'd1, 2'd3}, {2'd2, 2'd3, 2'd0, 2'd2}},
    '{{2'd0, 2'd1, 2'd2, 2'd3}, 8'h00},
    '{{2'd0, 2'd2, 2'd2, 2'd3}, 8'h00},
    '{{2'd0, 2'd2, 2'd1, 2'd3}, 8'h00},
    '{{2'd0, 2'd1, 2'd1, 2'd3}, 8'h00},
    '{{2'd0, 2'd1, 2'd0, 2'd2}, 8'h00},
    '{8'h00, 8'h00}
  };

  localparam logic [1:0] SEG_CNT [16] = '{
    2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1,
    2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0
  };

endpackage

// ===== rtl/msq_if.sv =====
// Channel interfaces: cell words in, segment words out
interface msq_in_if #(
  parameter int GRID_BITS   = 10,
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [GRID_BITS-1:0]          cell_x;
  logic [GRID_BITS-1:0]          cell_y;
  logic signed [SAMPLE_BITS-1:0] value_top_left;
  logic signed [SAMPLE_BITS-1:0] value_top_right;
  logic signed [SAMPLE_BITS-1:0] value_bottom_left;
  logic signed [SAMPLE_BITS-1:0] value_bottom_right;
  modport source (output valid, cell_x, cell_y, value_top_left, value_top_right,
                  value_bottom_left, value_bottom_right, input ready);
  modport sink (input valid, cell_x, cell_y, value_top_left, value_top_right,
                value_bottom_left, value_bottom_right, output ready);
endinterface

interface msq_out_if #(
  parameter int COORD_BITS = 23
) ();
  logic                  valid;
  logic                  ready;
  logic [3:0]            case_index;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic                  last_segment;
  modport source (output valid, case_index, start_x, start_y, end_x, end_y,
                  last_segment, input ready);
  modport sink (input valid, case_index, start_x, start_y, end_x, end_y,
                last_segment, output ready);
endinterface

// ===== rtl/msq_seg_front.sv =====
// Cell register, segment issue to divider row: one word per cycle while en is high
module msq_seg_front #(
  parameter int GRID_BITS   = 10,
  parameter int FRAC_BITS   = 12,
  parameter int SAMPLE_BITS = 16,
  parameter int REM_W       = SAMPLE_BITS + FRAC_BITS + 1,
  parameter int SIDE_W      = 5 + 2 * (2 * (GRID_BITS + FRAC_BITS + 1) + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [GRID_BITS-1:0]          cell_x,
  input  logic [GRID_BITS-1:0]          cell_y,
  input  logic signed [SAMPLE_BITS-1:0] value_tl,
  input  logic signed [SAMPLE_BITS-1:0] value_tr,
  input  logic signed [SAMPLE_BITS-1:0] value_bl,
  input  logic signed [SAMPLE_BITS-1:0] value_br,
  output logic                          seg_valid,
  output logic [REM_W-1:0]              seg_rem [2],
  output logic [SAMPLE_BITS-1:0]        seg_den [2],
  output logic [SIDE_W-1:0]             seg_side
);
  import msq_pkg::*;

  localparam int COORD_BITS = GRID_BITS + FRAC_BITS + 1;

  logic                          valid_r;
  logic                          k_r;
  logic [GRID_BITS-1:0]          cx_r, cy_r;
  logic signed [SAMPLE_BITS-1:0] s_r [4];
  logic [3:0]                    cs;
  logic [1:0]                    cnt;
  logic                          done;
  logic [7:0]                    pairs;
  logic [1:0]                    ca [2];
  logic [1:0]                    cb [2];
  logic [COORD_BITS-1:0]         bx [2];
  logic [COORD_BITS-1:0]         by [2];
  logic                          vert [2];

  function automatic logic [SAMPLE_BITS-1:0] mag_s(input logic signed [SAMPLE_BITS:0] v);
    logic signed [SAMPLE_BITS:0] m;
    m = v[SAMPLE_BITS] ? -v : v;
    return m[SAMPLE_BITS-1:0];
  endfunction

  assign cs    = {s_r[3][SAMPLE_BITS-1], s_r[2][SAMPLE_BITS-1],
                  s_r[1][SAMPLE_BITS-1], s_r[0][SAMPLE_BITS-1]};
  assign cnt   = SEG_CNT[cs];
  assign done  = (cnt != 2'd2) || k_r;
  assign pairs = SEG_TBL[cs][k_r];
  assign in_ready  = en && (!valid_r || done);
  assign seg_valid = valid_r && (cnt != 2'd0);

  always_comb begin
    ca[0] = pairs[7:6];
    cb[0] = pairs[5:4];
    ca[1] = pairs[3:2];
    cb[1] = pairs[1:0];
    for (int e = 0; e < 2; e++) begin
      logic signed [SAMPLE_BITS:0] va, vb;
      logic [SAMPLE_BITS-1:0]      num;
      va = {s_r[ca[e]][SAMPLE_BITS-1], s_r[ca[e]]};
      vb = {s_r[cb[e]][SAMPLE_BITS-1], s_r[cb[e]]};
      num = mag_s(va);
      seg_den[e] = mag_s(vb - va);
      seg_rem[e] = {1'b0, num, {FRAC_BITS{1'b0}}}
                   + REM_W'(seg_den[e] >> 1);
      bx[e] = {{1'b0, cx_r} + (GRID_BITS + 1)'(ca[e][0]), {FRAC_BITS{1'b0}}};
      by[e] = {{1'b0, cy_r} + (GRID_BITS + 1)'(ca[e][1]), {FRAC_BITS{1'b0}}};
      vert[e] = (ca[e][0] == cb[e][0]);
    end
  end

  assign seg_side = {cs, done, bx[0], by[0], vert[0], bx[1], by[1], vert[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= 1'b0;
    end else if (en) begin
      if (in_valid && in_ready) begin
        valid_r <= 1'b1;
        k_r     <= 1'b0;
      end else if (valid_r && !done) begin
        k_r <= 1'b1;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cx_r   <= cell_x;
      cy_r   <= cell_y;
      s_r[0] <= value_tl;
      s_r[1] <= value_tr;
      s_r[2] <= value_bl;
      s_r[3] <= value_br;
    end
  end
endmodule

// ===== rtl/msq_div_cell.sv =====
// Divider cell: one restoring quotient bit for both endpoints, sideband passed on
module msq_div_cell #(
  parameter int BIT         = 0,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 12,
  parameter int REM_W       = SAMPLE_BITS + FRAC_BITS + 1,
  parameter int SIDE_W      = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  logic [REM_W-1:0]       rem_i  [2],
  input  logic [SAMPLE_BITS-1:0] den_i  [2],
  input  logic [FRAC_BITS:0]     q_i    [2],
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [REM_W-1:0]       rem_o  [2],
  output logic [SAMPLE_BITS-1:0] den_o  [2],
  output logic [FRAC_BITS:0]     q_o    [2],
  output logic [SIDE_W-1:0]      side_o
);
  logic                   valid_r;
  logic [REM_W-1:0]       rem_r [2];
  logic [REM_W-1:0]       rem_nxt [2];
  logic [SAMPLE_BITS-1:0] den_r [2];
  logic [FRAC_BITS:0]     q_r [2];
  logic [FRAC_BITS:0]     q_nxt [2];
  logic [SIDE_W-1:0]      side_r;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      logic [REM_W-1:0] dsh;
      dsh = REM_W'(den_i[e]) << BIT;
      rem_nxt[e] = rem_i[e];
      q_nxt[e]   = q_i[e];
      if (rem_i[e] >= dsh) begin
        rem_nxt[e]    = rem_i[e] - dsh;
        q_nxt[e][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign q_o     = q_r;
  assign side_o  = side_r;
endmodule

// ===== rtl/marching_squares_cell_segments_top.sv =====
// Top level: marching squares contour segments for one grid cell per word
//
// in_chan takes one cell word: position of the top-left grid point and the
// four signed corner samples. out_chan gives one segment word per segment:
// case index, two fixed-point endpoints and a flag on the cell's last one.
// Cells with every corner inside or every corner outside give no segment word.
// An accepted cell passes the cell register, the divider row and the output
// register before its first segment word. Throughput: one segment word per
// cycle while out_chan does not stall, set by the issue register feeding
// the divider row one segment at a time; an ambiguous cell issues two.
// The divider row holds FRAC_BITS + 1 cells, one quotient bit each, with
// the two endpoint crossings of a segment worked side by side.
// Reset clears the valid bits of every stage; no word is in flight after it.
// When out_chan stalls, the whole row holds and in_chan ready drops; no cell
// is taken until the waiting output word is accepted.
module marching_squares_cell_segments_top #(
  parameter int GRID_BITS   = msq_pkg::GRID_BITS_DEF,
  parameter int FRAC_BITS   = msq_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = msq_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  msq_in_if.sink       in_chan,
  msq_out_if.source    out_chan
);
  `include "marching_squares_cell_segments_top_defines.svh"

  localparam int COORD_BITS = GRID_BITS + FRAC_BITS + 1;
  localparam int REM_W      = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int SIDE_W     = 5 + 2 * (2 * COORD_BITS + 1);
  localparam int NCELL      = FRAC_BITS + 1;

  logic                   en;
  logic                   out_valid_r;
  logic                   st_valid [NCELL+1];
  logic [REM_W-1:0]       st_rem   [NCELL+1][2];
  logic [SAMPLE_BITS-1:0] st_den   [NCELL+1][2];
  logic [FRAC_BITS:0]     st_q     [NCELL+1][2];
  logic [SIDE_W-1:0]      st_side  [NCELL+1];

  logic [3:0]             l_cs;
  logic                   l_last;
  logic [COORD_BITS-1:0]  l_bx [2];
  logic [COORD_BITS-1:0]  l_by [2];
  logic                   l_vert [2];
  logic [COORD_BITS-1:0]  px [2];
  logic [COORD_BITS-1:0]  py [2];

  assign en = !out_valid_r || out_chan.ready;

  msq_seg_front #(
    .GRID_BITS(GRID_BITS), .FRAC_BITS(FRAC_BITS), .SAMPLE_BITS(SAMPLE_BITS),
    .REM_W(REM_W), .SIDE_W(SIDE_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_chan.valid), .in_ready(in_chan.ready),
    .cell_x(in_chan.cell_x), .cell_y(in_chan.cell_y),
    .value_tl(in_chan.value_top_left), .value_tr(in_chan.value_top_right),
    .value_bl(in_chan.value_bottom_left), .value_br(in_chan.value_bottom_right),
    .seg_valid(st_valid[0]), .seg_rem(st_rem[0]), .seg_den(st_den[0]),
    .seg_side(st_side[0])
  );

  assign st_q[0][0] = '0;
  assign st_q[0][1] = '0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    msq_div_cell #(
      .BIT(FRAC_BITS - g), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS),
      .REM_W(REM_W), .SIDE_W(SIDE_W)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(st_valid[g]), .rem_i(st_rem[g]), .den_i(st_den[g]),
      .q_i(st_q[g]), .side_i(st_side[g]),
      .valid_o(st_valid[g+1]), .rem_o(st_rem[g+1]), .den_o(st_den[g+1]),
      .q_o(st_q[g+1]), .side_o(st_side[g+1])
    );
  end

  assign {l_cs, l_last, l_bx[0], l_by[0], l_vert[0], l_bx[1], l_by[1], l_vert[1]}
    = st_side[NCELL];

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      px[e] = l_bx[e] + (l_vert[e] ? '0 : COORD_BITS'(st_q[NCELL][e]));
      py[e] = l_by[e] + (l_vert[e] ? COORD_BITS'(st_q[NCELL][e]) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= st_valid[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_chan.case_index   <= l_cs;
      out_chan.start_x      <= px[0];
      out_chan.start_y      <= py[0];
      out_chan.end_x        <= px[1];
      out_chan.end_y        <= py[1];
      out_chan.last_segment <= l_last;
    end
  end

  assign out_chan.valid = out_valid_r;

  `MSQ_ASSERT_NOW(a_ready_needs_advance, in_chan.ready, en)
  `MSQ_ASSERT_NEXT(a_stall_keeps_word, out_valid_r && !out_chan.ready, out_valid_r)
  `MSQ_ASSERT_NEXT(a_row_feeds_output, en && st_valid[NCELL], out_valid_r)
  `MSQ_ASSERT_NOW(a_no_empty_case, out_valid_r,
                  out_chan.case_index != 4'd0 && out_chan.case_index != 4'd15)
endmodule

// ===== dv/marching_squares_cell_segments_top_test.sv =====
// Testbench: marching squares segment block against its own segment predictor
`timescale 1ns / 100ps

module marching_squares_cell_segments_top_test;
  import msq_pkg::*;

  localparam int GB = GRID_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int SB = SAMPLE_BITS_DEF;
  localparam int CB = GB + FB + 1;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [GB-1:0] cx;
    logic [GB-1:0] cy;
    logic signed [SB-1:0] v[4];
  } cell_t;

  typedef struct {
    logic [3:0] cs;
    logic [CB-1:0] sx, sy, ex, ey;
    logic last;
  } seg_t;

  class segment_board;
    seg_t pending[$];
    int errors = 0;
    int cells = 0;
    int segs = 0;

    function void edge_point(cell_t c, int a, int b,
                             output logic [CB-1:0] px,
                             output logic [CB-1:0] py);
      longint sa, sb, num, den, t, bx, by;
      sa = c.v[a];
      sb = c.v[b];
      num = sa < 0 ? -sa : sa;
      den = sb - sa;
      if (den < 0) den = -den;
      t = 0;
      if (den != 0) t = ((num << FB) + (den >> 1)) / den;
      bx = (longint'(c.cx) + (a & 1)) << FB;
      by = (longint'(c.cy) + (a >> 1)) << FB;
      if ((b & 1) != (a & 1)) bx += t;
      else by += t;
      px = bx[CB-1:0];
      py = by[CB-1:0];
    endfunction

    function void note_cell(cell_t c);
      logic [3:0] cs;
      int n;
      int pairs[2][4];
      seg_t s;
      cs = 0;
      for (int k = 0; k < 4; k++) if (c.v[k] < 0) cs[k] = 1'b1;
      cells++;
      case (cs)
        4'd1: pairs[0] = '{0, 2, 0, 1};
        4'd2, 4'd13: pairs[0] = '{0, 1, 1, 3};
        4'd3, 4'd12: pairs[0] = '{0, 2, 1, 3};
        4'd4, 4'd11: pairs[0] = '{0, 2, 2, 3};
        4'd5, 4'd10: pairs[0] = '{0, 1, 2, 3};
        4'd7, 4'd8: pairs[0] = '{2, 3, 1, 3};
        4'd14: pairs[0] = '{0, 1, 0, 2};
        4'd6: begin
          pairs[0] = '{0, 1, 0, 2};
          pairs[1] = '{2, 3, 1, 3};
        end
        4'd9: begin
          pairs[0] = '{0, 1, 1, 3};
          pairs[1] = '{2, 3, 0, 2};
        end
        default: ;
      endcase
      n = (cs == 4'd0 || cs == 4'd15) ? 0 : ((cs == 4'd6 || cs == 4'd9) ? 2 : 1);
      for (int k = 0; k < n; k++) begin
        s.cs = cs;
        edge_point(c, pairs[k][0], pairs[k][1], s.sx, s.sy);
        edge_point(c, pairs[k][2], pairs[k][3], s.ex, s.ey);
        s.last = (k + 1 == n);
        pending.insert(pending.size(), s);
      end
    endfunction

    function void check_segment(seg_t got);
      seg_t w;
      segs++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected segment word cs=%0d", $time, got.cs);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.cs !== w.cs) begin
        $display("%0t: case_index exp %0d got %0d", $time, w.cs, got.cs); errors++;
      end
      if (got.sx !== w.sx) begin
        $display("%0t: start_x exp %0h got %0h", $time, w.sx, got.sx); errors++;
      end
      if (got.sy !== w.sy) begin
        $display("%0t: start_y exp %0h got %0h", $time, w.sy, got.sy); errors++;
      end
      if (got.ex !== w.ex) begin
        $display("%0t: end_x exp %0h got %0h", $time, w.ex, got.ex); errors++;
      end
      if (got.ey !== w.ey) begin
        $display("%0t: end_y exp %0h got %0h", $time, w.ey, got.ey); errors++;
      end
      if (got.last !== w.last) begin
        $display("%0t: last_segment exp %0b got %0b", $time, w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  segment_board board = new();
  int idle_cycles = 0;
  bit stall_mode = 0;

  msq_in_if #(.GRID_BITS(GB), .SAMPLE_BITS(SB)) in_chan ();
  msq_out_if #(.COORD_BITS(CB)) out_chan ();

  marching_squares_cell_segments_top #(
    .GRID_BITS(GB), .FRAC_BITS(FB), .SAMPLE_BITS(SB)
  ) i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.cell_x = '0;
    in_chan.cell_y = '0;
    in_chan.value_top_left = '0;
    in_chan.value_top_right = '0;
    in_chan.value_bottom_left = '0;
    in_chan.value_bottom_right = '0;
    out_chan.ready = 1'b0;
  end

  // receiver: alternate between a no-stall stretch and a random-stall stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
      out_chan.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
      if (out_chan.valid && out_chan.ready)
        board.check_segment('{out_chan.case_index, out_chan.start_x, out_chan.start_y,
                              out_chan.end_x, out_chan.end_y, out_chan.last_segment});
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_cell(cell_t c);
    in_chan.valid <= 1'b1;
    in_chan.cell_x <= c.cx;
    in_chan.cell_y <= c.cy;
    in_chan.value_top_left <= c.v[0];
    in_chan.value_top_right <= c.v[1];
    in_chan.value_bottom_left <= c.v[2];
    in_chan.value_bottom_right <= c.v[3];
    do @(posedge clk); while (!in_chan.ready);
    board.note_cell(c);
  endtask

  task automatic pause_sender(int n);
    in_chan.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return SB'($urandom_range(0, 4)) - SB'(2);
      3: return SB'($urandom_range(0, 200)) - SB'(100);
      default: return SB'($urandom);
    endcase
  endfunction

  initial begin
    cell_t c;
    int burst;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int cs = 0; cs < 16; cs++) begin
      c.cx = (cs & 1) ? '1 : '0;
      c.cy = (cs & 2) ? '1 : '0;
      for (int k = 0; k < 4; k++)
        c.v[k] = ((cs >> k) & 1) ? -16'sd32768 : 16'sd32767;
      send_cell(c);
    end
    c.cx = 10'd5; c.cy = 10'd7;
    c.v = '{16'sd0, -16'sd1, 16'sd0, 16'sd0};
    send_cell(c);
    c.v = '{-16'sd1, 16'sd1, 16'sd1, -16'sd1};
    send_cell(c);
    c.v = '{16'sd3, -16'sd1, -16'sd2, 16'sd0};
    send_cell(c);
    c.v = '{-16'sd32768, 16'sd0, 16'sd32767, -16'sd1};
    send_cell(c);
    pause_sender(1);
    while (board.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < 750; ) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && i < 750; j++, i++) begin
        c.cx = GB'($urandom);
        c.cy = GB'($urandom);
        for (int k = 0; k < 4; k++) c.v[k] = rand_sample();
        send_cell(c);
      end
      if (i == 375) begin
        pause_sender(1);
        while (board.pending.size() != 0) @(posedge clk);
      end else if (i < 750 && $urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end
    in_chan.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (FB + 20) @(posedge clk);
    $display("Sent %0d cells covering all sixteen corner cases, extreme and zero samples,",
             board.cells);
    $display("and checked %0d segment words under random gaps and stalls.", board.segs);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/msq_pkg.sv
rtl/msq_if.sv
rtl/msq_seg_front.sv
rtl/msq_div_cell.sv
rtl/marching_squares_cell_segments_top.sv
dv/marching_squares_cell_segments_top_test.sv
